// ===== hdl/mcc_pkg.sv =====
// mcc_pkg: shared types, constants and helpers for the minimum-coin change table.
// No dependencies; used by every interface and by every module of the block but mcc_ram.
package mcc_pkg;

  localparam int NUM_DENOMS = 5;
  localparam int AMT_W      = 7;
  localparam int CNT_W      = 7;
  localparam int DENOM_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int SEL_W      = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef logic [AMT_W-1:0]     amt_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [DENOM_W-1:0]   denom_t;
  typedef logic [SEL_W-1:0]     sel_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef denom_t [NUM_DENOMS-1:0] denom_arr_t;

  // one table entry: 1 + 7 + 5*7 = 43 bits
  typedef struct packed {
    logic                         reach;
    cnt_t                         total;
    logic [NUM_DENOMS-1:0][CNT_W-1:0] cnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam entry_t EMPTY_ENTRY = '{reach: 1'b1, total: '0, cnt: '0};
  localparam entry_t NONE_ENTRY  = '{reach: 1'b0, total: '0, cnt: '0};

  localparam denom_arr_t DENOM_RESET = {8'd40, 8'd25, 8'd8, 8'd5, 8'd1};

  localparam sel_t LAST_SEL = SEL_W'(NUM_DENOMS - 1);

  // saturating increment of a coin counter
  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + cnt_t'(1);
  endfunction

endpackage

// ===== hdl/mcc_in_if.sv =====
// mcc_in_if: input channel, one amount per item.
// Depends on mcc_pkg.
interface mcc_in_if;
  logic          valid;
  logic          ready;
  mcc_pkg::amt_t amount;

  modport source (output valid, output amount, input ready);
  modport sink   (input valid, input amount, output ready);
endinterface

// ===== hdl/mcc_out_if.sv =====
// mcc_out_if: result channel, one solved amount per item.
// Depends on mcc_pkg.
interface mcc_out_if;
  logic          valid;
  logic          ready;
  mcc_pkg::amt_t amount_echo;
  logic          reachable;
  mcc_pkg::cnt_t coins_total;
  mcc_pkg::cnt_t count_1;
  mcc_pkg::cnt_t count_2;
  mcc_pkg::cnt_t count_3;
  mcc_pkg::cnt_t count_4;
  mcc_pkg::cnt_t count_5;

  modport source (output valid, output amount_echo, output reachable, output coins_total,
                  output count_1, output count_2, output count_3, output count_4,
                  output count_5, input ready);
  modport sink   (input valid, input amount_echo, input reachable, input coins_total,
                  input count_1, input count_2, input count_3, input count_4,
                  input count_5, output ready);
endinterface

// ===== hdl/mcc_cfg_if.sv =====
// mcc_cfg_if: register write channel (index, data).
// Depends on mcc_pkg.
interface mcc_cfg_if;
  logic              valid;
  logic              ready;
  mcc_pkg::cfg_idx_t index;
  mcc_pkg::denom_t   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/mcc_ram.sv =====
// mcc_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies. Read during write to the same address returns the old data.
module mcc_ram #(
  parameter  int WIDTH  = 8,
  parameter  int DEPTH  = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mcc_cfg_regs.sv =====
// mcc_cfg_regs: the five denomination registers behind the configuration channel.
// Depends on mcc_pkg and mcc_cfg_if. Indexes past the last register are dropped.
module mcc_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  mcc_cfg_if.sink             cfg_ch,
  output mcc_pkg::denom_arr_t denoms
);

  mcc_pkg::denom_arr_t denoms_r;

  assign cfg_ch.ready = 1'b1;
  assign denoms       = denoms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      denoms_r <= mcc_pkg::DENOM_RESET;
    end else if (cfg_ch.valid) begin
      for (int i = 0; i < mcc_pkg::NUM_DENOMS; i++) begin
        if (cfg_ch.index == mcc_pkg::CFG_IDX_W'(i)) begin
          denoms_r[i] <= cfg_ch.data;
        end
      end
    end
  end

endmodule

// ===== hdl/mcc_step.sv =====
// mcc_step: one relaxation step, tries one denomination against the running best.
// Depends on mcc_pkg. Purely combinational; the caller registers the result.
module mcc_step (
  input  mcc_pkg::amt_t   amt,
  input  mcc_pkg::denom_t denom,
  input  mcc_pkg::sel_t   sel,
  input  mcc_pkg::entry_t src,
  input  mcc_pkg::entry_t best,
  output mcc_pkg::entry_t best_nxt
);

  logic            usable;
  logic            take;
  mcc_pkg::amt_t   diff;
  mcc_pkg::entry_t src_eff;

  always_comb begin
    usable  = (denom != '0) && (denom <= {1'b0, amt});
    diff    = amt - denom[mcc_pkg::AMT_W-1:0];
    // a difference of zero means the empty entry, not the table
    src_eff = (diff == '0) ? mcc_pkg::EMPTY_ENTRY : src;
    take    = usable && src_eff.reach && (!best.reach || (src_eff.total < best.total));

    best_nxt = best;
    if (take) begin
      best_nxt          = src_eff;
      best_nxt.total    = mcc_pkg::sat_inc(src_eff.total);
      best_nxt.cnt[sel] = mcc_pkg::sat_inc(src_eff.cnt[sel]);
    end
  end

endmodule

// ===== hdl/min_coin_change_table_top.sv =====
// min_coin_change_table_top: minimum-coin exact change table, top level.
// Depends on mcc_pkg, the mcc_*_if interfaces, mcc_ram, mcc_cfg_regs and mcc_step.
//
//   channel | dir  | payload                                         | accept
//   --------+------+-------------------------------------------------+----------------
//   in_ch   | in   | amount                                          | valid & ready
//   out_ch  | out  | amount_echo, reachable, coins_total, count_1..5 | valid & ready
//   cfg_ch  | in   | index, data (denomination_1..5 at index 0..4)   | valid (ready=1)
//
// Sequence: an item takes one table read per denomination through the single
//   read port of the table RAM; the next item is accepted in the finishing cycle.
// The finishing cycle writes the entry back; a read of that same entry by the next item in
//   the same cycle is served from a forwarding register.
// Stalls: the result sits in an output register; the block holds in its finishing cycle
//   only while that register is still full and not taken.
// Reset: synchronous, active low; control and denominations only. The user must send
//   amounts ascending (not enforced); every entry is then written before use, no clearing.
module min_coin_change_table_top #(
  parameter int MAX_AMOUNT = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  mcc_in_if.sink    in_ch,
  mcc_out_if.source out_ch,
  mcc_cfg_if.sink   cfg_ch
);

  // amounts are 7 bits, so the table never needs more than 128 entries
  localparam int TBL_DEPTH = (MAX_AMOUNT < 128) ? MAX_AMOUNT : 128;
  localparam int ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_t;

  state_t              state_r;
  mcc_pkg::sel_t       ev_sel_r;    // denomination whose read data arrives this cycle
  mcc_pkg::amt_t       amt_r;
  mcc_pkg::entry_t     best_r;
  logic                fwd_hit_r;
  mcc_pkg::entry_t     fwd_data_r;
  logic                out_valid_r;
  mcc_pkg::amt_t       out_amt_r;
  mcc_pkg::entry_t     out_ent_r;

  mcc_pkg::denom_arr_t denoms;

  logic                in_acc;
  logic                last_ev;
  logic                mid_item;
  logic                go;
  logic                rd_en;
  mcc_pkg::sel_t       rd_sel;
  mcc_pkg::amt_t       rd_amt;
  mcc_pkg::amt_t       rd_diff;
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic                wr_en;
  logic                in_range;
  logic                fwd_hit_nxt;
  logic [mcc_pkg::ENTRY_W-1:0] ram_rdata;
  mcc_pkg::entry_t     src_ent;
  mcc_pkg::entry_t     best_nxt;
  mcc_pkg::entry_t     final_ent;

  mcc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .denoms (denoms)
  );

  // ---- control -----------------------------------------------------------
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign last_ev  = (ev_sel_r == mcc_pkg::LAST_SEL);
  assign mid_item = (state_r == ST_BUSY) && !last_ev;
  assign go       = (state_r == ST_BUSY) && last_ev && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == ST_IDLE) || go;

  // ---- table read: first denomination on accept, the rest while busy ------
  assign rd_en   = in_acc || mid_item;
  assign rd_sel  = mid_item ? ev_sel_r + mcc_pkg::sel_t'(1) : '0;
  assign rd_amt  = mid_item ? amt_r : in_ch.amount;
  assign rd_diff = rd_amt - denoms[rd_sel][mcc_pkg::AMT_W-1:0];
  assign rd_addr = ADDR_W'(rd_diff);

  mcc_ram #(
    .WIDTH (mcc_pkg::ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (final_ent),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // RAM returns old data on a same-cycle collision; patch it from the write
  assign src_ent = fwd_hit_r ? fwd_data_r : mcc_pkg::entry_t'(ram_rdata);

  mcc_step u_step (
    .amt      (amt_r),
    .denom    (denoms[ev_sel_r]),
    .sel      (ev_sel_r),
    .src      (src_ent),
    .best     (best_r),
    .best_nxt (best_nxt)
  );

  // ---- finish: amount zero and out-of-table amounts are special -----------
  assign in_range = (32'(amt_r) < TBL_DEPTH);

  always_comb begin
    if (amt_r == '0) begin
      final_ent = mcc_pkg::EMPTY_ENTRY;
    end else if (in_range) begin
      final_ent = best_nxt;
    end else begin
      final_ent = mcc_pkg::NONE_ENTRY;
    end
  end

  assign wr_en       = go && in_range && (amt_r != '0);
  assign wr_addr     = ADDR_W'(amt_r);
  assign fwd_hit_nxt = wr_en && (wr_addr == rd_addr);

  // ---- registers ----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ev_sel_r    <= '0;
      out_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      if (rd_en) begin
        fwd_hit_r  <= fwd_hit_nxt;
        fwd_data_r <= final_ent;
      end

      if (go) begin
        out_valid_r <= 1'b1;
        out_amt_r   <= amt_r;
        out_ent_r   <= final_ent;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      // a new item may start in the finishing cycle of the previous one
      if (in_acc) begin
        state_r  <= ST_BUSY;
        amt_r    <= in_ch.amount;
        best_r   <= mcc_pkg::NONE_ENTRY;
        ev_sel_r <= '0;
      end else if (mid_item) begin
        best_r   <= best_nxt;
        ev_sel_r <= ev_sel_r + mcc_pkg::sel_t'(1);
      end else if (go) begin
        state_r  <= ST_IDLE;
      end
    end
  end

  // ---- result channel; total and counts read zero when unreachable -------
  assign out_ch.valid       = out_valid_r;
  assign out_ch.amount_echo = out_amt_r;
  assign out_ch.reachable   = out_ent_r.reach;
  assign out_ch.coins_total = out_ent_r.reach ? out_ent_r.total  : '0;
  assign out_ch.count_1     = out_ent_r.reach ? out_ent_r.cnt[0] : '0;
  assign out_ch.count_2     = out_ent_r.reach ? out_ent_r.cnt[1] : '0;
  assign out_ch.count_3     = out_ent_r.reach ? out_ent_r.cnt[2] : '0;
  assign out_ch.count_4     = out_ent_r.reach ? out_ent_r.cnt[3] : '0;
  assign out_ch.count_5     = out_ent_r.reach ? out_ent_r.cnt[4] : '0;

  // ---- assertions ---------------------------------------------------------
  a_wr_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_BUSY) && last_ev && (!out_valid_r || out_ch.ready))
    else $error("table written outside the finishing cycle");

  a_accept_starts_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_BUSY) && (ev_sel_r == '0))
    else $error("accepted item did not start at the first denomination");

  a_sel_steps: assert property (@(posedge clk) disable iff (!rst_n)
    mid_item |=> (state_r == ST_BUSY) && (ev_sel_r == $past(ev_sel_r) + mcc_pkg::sel_t'(1)))
    else $error("denomination sequence skipped or stalled");

  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(go))
    else $error("result appeared without a finished item");

endmodule

// ===== dv/change_table_checker.sv =====
// change_table_checker: watches the amount, result and register channels of the
// minimum-coin change table, solves every amount on its own copy of the table and
// compares each result field by field. Depends on mcc_pkg and the mcc_*_if interfaces.
module change_table_checker #(
  parameter int MAX_AMOUNT = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  mcc_in_if           in_ch,
  mcc_out_if          out_ch,
  mcc_cfg_if          cfg_ch,
  output int unsigned mismatches,
  output int unsigned results_checked
);
  import mcc_pkg::*;

  typedef struct {
    amt_t   amt;
    entry_t ent;
  } solved_t;

  entry_t      coin_table [MAX_AMOUNT];
  denom_arr_t  denom_vals;
  solved_t     solved_q [$];
  int unsigned err_cnt  = 0;
  int unsigned done_cnt = 0;

  function automatic cnt_t bump(input cnt_t v);
    return (v == COUNT_MAX) ? v : v + cnt_t'(1);
  endfunction

  // fewest coins for one amount; earlier denominations win ties
  function automatic entry_t solve_amount(input amt_t amt);
    entry_t best;
    entry_t src;
    int     diff;
    best = NONE_ENTRY;
    if (amt == 0) return EMPTY_ENTRY;
    if (int'(amt) >= MAX_AMOUNT) return NONE_ENTRY;
    for (int i = 0; i < NUM_DENOMS; i++) begin
      if (denom_vals[i] == 0 || denom_vals[i] > amt) continue;
      diff = int'(amt) - int'(denom_vals[i]);
      if (diff == 0) src = EMPTY_ENTRY;
      else if (diff < MAX_AMOUNT) src = coin_table[diff];
      else src = NONE_ENTRY;
      if (!src.reach) continue;
      if (!best.reach || src.total < best.total) begin
        best        = src;
        best.total  = bump(src.total);
        best.cnt[i] = bump(src.cnt[i]);
      end
    end
    coin_table[amt] = best;
    return best;
  endfunction

  task automatic check_field(input string name, input amt_t at,
                             input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: amount %0d %s mismatch, expected %0d, got %0d",
               $time, at, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    solved_t want;
    if (!rst_n) begin
      denom_vals = DENOM_RESET;
      solved_q.delete();
    end else begin
      // results first: a result never belongs to an amount taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (solved_q.size() == 0) begin
          $display("%0t: unexpected result for amount %0d, expected none, got one",
                   $time, out_ch.amount_echo);
          err_cnt++;
        end else begin
          want = solved_q.pop_front();
          check_field("amount_echo", want.amt, 8'(want.amt), 8'(out_ch.amount_echo));
          check_field("reachable", want.amt, 8'(want.ent.reach), 8'(out_ch.reachable));
          check_field("coins_total", want.amt, 8'(want.ent.total), 8'(out_ch.coins_total));
          check_field("count_1", want.amt, 8'(want.ent.cnt[0]), 8'(out_ch.count_1));
          check_field("count_2", want.amt, 8'(want.ent.cnt[1]), 8'(out_ch.count_2));
          check_field("count_3", want.amt, 8'(want.ent.cnt[2]), 8'(out_ch.count_3));
          check_field("count_4", want.amt, 8'(want.ent.cnt[3]), 8'(out_ch.count_4));
          check_field("count_5", want.amt, 8'(want.ent.cnt[4]), 8'(out_ch.count_5));
          done_cnt++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < NUM_DENOMS)
        denom_vals[cfg_ch.index] = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        want.amt = in_ch.amount;
        want.ent = solve_amount(in_ch.amount);
        solved_q.push_back(want);
      end
    end
    mismatches      <= err_cnt;
    results_checked <= done_cnt;
  end

endmodule

// ===== dv/min_coin_change_table_top_tb.sv =====
// min_coin_change_table_top_tb: stimulus and verdict for the minimum-coin change table.
// Depends on mcc_pkg, the mcc_*_if interfaces, min_coin_change_table_top and
// change_table_checker, which does all prediction and comparison.
module min_coin_change_table_top_tb;
  import mcc_pkg::*;

  localparam int MAX_AMOUNT  = 128;
  localparam int ITEM_TARGET = 1900;   // stop opening new phases past this
  localparam int PHASE_ITEMS = 150;    // amounts per denomination setting
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int STALL_LIMIT = 4000;   // cycles with no handshake at all
  localparam int TAIL_CYCLES = 20;     // catch stray results after the drain

  logic clk;
  logic rst_n;

  mcc_in_if  in_ch();
  mcc_out_if out_ch();
  mcc_cfg_if cfg_ch();

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned items_sent      = 0;
  int unsigned settings_loaded = 0;
  int unsigned send_idle_pct   = 0;    // sender gap odds, per cycle
  int unsigned stall_pct       = 0;    // receiver stall odds, per cycle
  int unsigned hold_reqs       = 0;    // bumped by stimulus to ask for a hold-off
  int unsigned hold_seen       = 0;
  int unsigned hold_left       = 0;
  int unsigned quiet_cycles    = 0;

  min_coin_change_table_top #(
    .MAX_AMOUNT(MAX_AMOUNT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  change_table_checker #(
    .MAX_AMOUNT(MAX_AMOUNT)
  ) u_change_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .cfg_ch         (cfg_ch),
    .mismatches     (mismatches),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stalls, or a solid hold-off when stimulus asks for one.
  // The hold-off is counted here so the sender keeps pushing meanwhile and the
  // block backs up into its input.
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: any accepted item on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d of %0d results seen",
               $time, STALL_LIMIT, results_checked, items_sent);
      $display("FAIL min_coin_change_table_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // denominations given first to fifth
  function automatic denom_arr_t coin_set(input int d1, d2, d3, d4, d5);
    return {denom_t'(d5), denom_t'(d4), denom_t'(d3), denom_t'(d2), denom_t'(d1)};
  endfunction

  // biased toward small coins so most amounts stay reachable
  function automatic denom_t random_coin();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 15) return '0;
    if (pick < 25) return denom_t'($urandom_range(255, 128));
    if (pick < 60) return denom_t'($urandom_range(6, 1));
    return denom_t'($urandom_range(127, 1));
  endfunction

  // Fixed settings first, corners included, then random ones.
  function automatic denom_arr_t phase_coins(input int phase);
    case (phase)
      0:       return coin_set(1, 2, 3, 4, 5);          // many equal-count ties
      1:       return coin_set(0, 0, 0, 0, 0);          // nothing usable
      2:       return coin_set(255, 255, 255, 255, 255);  // all larger than any amount
      3:       return coin_set(1, 0, 0, 0, 0);          // counts climb to 127
      4:       return coin_set(0, 0, 0, 0, 127);        // only the top amount pays
      5:       return coin_set(2, 4, 6, 8, 10);         // odd amounts unreachable
      6:       return coin_set(128, 3, 0, 255, 7);
      7:       return coin_set(1, 5, 8, 25, 40);
      default: return {random_coin(), random_coin(), random_coin(), random_coin(),
                       random_coin()};
    endcase
  endfunction

  // Offer one amount; valid only drops when a gap is actually taken.
  task automatic push_amount(input amt_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.amount <= a;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Register writes go back to back, then valid drops.
  task automatic load_denoms(input denom_arr_t set);
    for (int i = 0; i < NUM_DENOMS; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= cfg_idx_t'(i);
      cfg_ch.data  <= set[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
    settings_loaded++;
  endtask

  // Every amount gives exactly one result, so the block is idle once all are back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (results_checked != items_sent) @(posedge clk);
  endtask

  initial begin
    int          phase;
    int unsigned phase_start;
    int unsigned top_amt;
    int unsigned mode;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.amount  <= '0;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.index  <= '0;
    cfg_ch.data   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, reset denominations: zero amount, a climb from one, a repeat,
    // an out-of-order amount and zero again.
    push_amount(amt_t'(0));
    for (int a = 1; a <= 20; a++) push_amount(amt_t'(a));
    push_amount(amt_t'(20));
    push_amount(amt_t'(13));
    push_amount(amt_t'(0));
    // finish the climb so every table entry has been written before any
    // random amount can read it
    for (int a = 21; a <= 127; a++) push_amount(amt_t'(a));

    // Random phases: one denomination setting each, idle mix rotating through
    // none / sender 60 / receiver 60 / both 27.
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      drain();
      load_denoms(phase_coins(phase));
      mode = phase % 4;
      send_idle_pct = (mode == 1) ? 60 : (mode == 3) ? 27 : 0;
      stall_pct    <= (mode == 2) ? 60 : (mode == 3) ? 27 : 0;
      // long output hold-off while the sender runs flat out
      if (mode == 0) hold_reqs <= hold_reqs + 1;
      phase_start = items_sent;
      // fixed settings open with a full climb so the top amount is solved fresh
      if (phase < 8)
        for (int a = 1; a <= 127; a++) push_amount(amt_t'(a));
      while (items_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(99) < 75) begin
          // well-formed climb from one rebuilds the table for this setting
          top_amt = $urandom_range(127, 1);
          for (int a = 1; a <= top_amt; a++) push_amount(amt_t'(a));
        end else begin
          // any amount, repeats and zero included, against the table as it stands
          repeat ($urandom_range(8, 1)) push_amount(amt_t'($urandom_range(127, 0)));
        end
      end
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d amounts across %0d written coin settings plus reset values,",
             items_sent, settings_loaded);
    $display("with %0d results compared and %0d long result hold-offs.",
             results_checked, hold_reqs);
    if (mismatches == 0) begin
      $display("PASS min_coin_change_table_top");
    end else begin
      $display("FAIL min_coin_change_table_top");
    end
    $finish;
  end

endmodule
